/* rtl/sdd_pkg.sv */
// Shared constants and types for the stereo depth from disparity block
`default_nettype none

package sdd_pkg;

    localparam int COL_W       = 12;
    localparam int DISP_W      = 16;
    localparam int CFG_W       = 32;
    localparam int DEPTH_W     = 32;
    localparam int MAX_COLUMNS = 4096;
    localparam int ADDR_W      = 5;
    localparam int PL_W        = COL_W + CFG_W;            // col * inv_focal_left
    localparam int DIFF_W      = COL_W + 4 + 2;            // col*16 - disparity, signed
    localparam int PR_W        = DIFF_W + CFG_W + 1;       // diff * inv_focal_right, signed
    localparam int XW          = 52;                       // xl, xr, den in Q.36
    localparam int REM_W       = XW + 1;
    localparam int Q_W         = 32;                       // quotient bits resolved
    localparam int NUM_SH      = 4;                        // |base| << 28 split at bit 32

    localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};

    typedef struct packed {
        logic        [CFG_W-1:0] inv_focal_left;
        logic signed [CFG_W-1:0] offset_left;
        logic        [CFG_W-1:0] inv_focal_right;
        logic signed [CFG_W-1:0] offset_right;
        logic signed [CFG_W-1:0] stereo_baseline;
    } cfg_t;

    typedef struct packed {
        logic dvalid;       // disparity nonzero
        logic zero;         // denominator zero
        logic neg;          // quotient negative
        logic base_neg;
        logic base_zero;
        logic ovf;          // quotient >= 2^32
    } ctl_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [REM_W-1:0] rem;
        logic [XW-1:0]    dmag;
        logic [Q_W-1:0]   num;
        logic [Q_W-1:0]   q;
    } div_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               depth_valid;
        logic               saturated;
    } res_t;

endpackage

`default_nettype wire

/* rtl/sdd_cfg.sv */
// APB configuration registers
`default_nettype none

module sdd_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sdd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output sdd_pkg::cfg_t              cfg
);
    import sdd_pkg::*;

    typedef enum logic [2:0] {
        REG_INV_FOCAL_LEFT  = 3'd0,
        REG_OFFSET_LEFT     = 3'd1,
        REG_INV_FOCAL_RIGHT = 3'd2,
        REG_OFFSET_RIGHT    = 3'd3,
        REG_BASELINE        = 3'd4
    } reg_idx_t;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_INV_FOCAL_LEFT:  cfg_reg.inv_focal_left  <= pwdata;
                REG_OFFSET_LEFT:     cfg_reg.offset_left     <= pwdata;
                REG_INV_FOCAL_RIGHT: cfg_reg.inv_focal_right <= pwdata;
                REG_OFFSET_RIGHT:    cfg_reg.offset_right    <= pwdata;
                REG_BASELINE:        cfg_reg.stereo_baseline <= pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_INV_FOCAL_LEFT:  prdata = cfg_reg.inv_focal_left;
            REG_OFFSET_LEFT:     prdata = cfg_reg.offset_left;
            REG_INV_FOCAL_RIGHT: prdata = cfg_reg.inv_focal_right;
            REG_OFFSET_RIGHT:    prdata = cfg_reg.offset_right;
            REG_BASELINE:        prdata = cfg_reg.stereo_baseline;
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/sdd_front.sv */
// Front pipeline: abscissa products, denominator, magnitudes and overflow test
`default_nettype none

module sdd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  sdd_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    input  logic [sdd_pkg::COL_W-1:0]  column,
    input  logic [sdd_pkg::DISP_W-1:0] disparity_value,
    output logic                       out_valid,
    output sdd_pkg::div_t              out_item
);
    import sdd_pkg::*;

    // stage 1: products
    logic                     v1_reg;
    logic                     dv1_reg;
    logic [PL_W-1:0]          pl1_reg;
    logic signed [PR_W-1:0]   pr1_reg;
    // stage 2: xl, xr
    logic                     v2_reg;
    logic                     dv2_reg;
    logic signed [XW-1:0]     xl2_reg;
    logic signed [XW-1:0]     xr2_reg;
    // stage 3: denominator
    logic                     v3_reg;
    logic                     dv3_reg;
    logic signed [XW-1:0]     den3_reg;
    // stage 4: magnitudes
    logic                     v4_reg;
    ctl_t                     ctl4_reg;
    logic [XW-1:0]            dmag4_reg;
    logic [CFG_W-1:0]         absb4_reg;
    // stage 5: overflow test, divider setup
    logic                     v5_reg;
    div_t                     d5_reg;

    logic [COL_W-1:0]         col_c;
    logic signed [DIFF_W-1:0] diff_c;
    logic [PL_W-1:0]          pl_c;
    logic signed [PR_W-1:0]   pr_c;
    logic signed [XW-1:0]     xl_c;
    logic signed [XW-1:0]     xr_c;
    logic [CFG_W-1:0]         absb_c;
    ctl_t                     ctl_c;
    div_t                     d_c;
    logic [XW-1:0]            bhi_c;

    assign col_c  = (32'(column) > MAX_COLUMNS - 1) ? COL_W'(MAX_COLUMNS - 1) : column;
    assign diff_c = $signed({2'b00, col_c, 4'b0000}) - $signed({2'b00, disparity_value});
    assign pl_c   = PL_W'(col_c) * PL_W'(cfg.inv_focal_left);
    assign pr_c   = diff_c * $signed({1'b0, cfg.inv_focal_right});

    // xl = (col*ifl + offl*16)*16, xr = diff*ifr + offr*256, all Q.36
    assign xl_c = ($signed({{(XW-PL_W){1'b0}}, pl1_reg})
                 + $signed({{(XW-CFG_W-4){cfg.offset_left[CFG_W-1]}},
                            cfg.offset_left, 4'b0000})) <<< 4;
    assign xr_c = $signed({{(XW-PR_W){pr1_reg[PR_W-1]}}, pr1_reg})
                + $signed({{(XW-CFG_W-8){cfg.offset_right[CFG_W-1]}},
                           cfg.offset_right, 8'h00});

    assign absb_c = cfg.stereo_baseline[CFG_W-1] ? (~cfg.stereo_baseline + 1'b1)
                                                 : cfg.stereo_baseline;

    always_comb
    begin
        ctl_c           = '0;
        ctl_c.dvalid    = dv3_reg;
        ctl_c.zero      = (den3_reg == '0);
        ctl_c.base_neg  = cfg.stereo_baseline[CFG_W-1];
        ctl_c.base_zero = (cfg.stereo_baseline == '0);
        ctl_c.neg       = cfg.stereo_baseline[CFG_W-1] ^ den3_reg[XW-1];
    end

    // q >= 2^32 exactly when |base| >> 4 >= dmag
    assign bhi_c = XW'(absb4_reg[CFG_W-1:NUM_SH]);

    always_comb
    begin
        d_c         = '0;
        d_c.ctl     = ctl4_reg;
        d_c.ctl.ovf = (bhi_c >= dmag4_reg);
        d_c.rem     = d_c.ctl.ovf ? '0 : REM_W'(bhi_c);
        d_c.dmag    = dmag4_reg;
        d_c.num     = {absb4_reg[NUM_SH-1:0], {(Q_W-NUM_SH){1'b0}}};
        d_c.q       = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv1_reg   <= (disparity_value != '0);
            pl1_reg   <= pl_c;
            pr1_reg   <= pr_c;
            dv2_reg   <= dv1_reg;
            xl2_reg   <= xl_c;
            xr2_reg   <= xr_c;
            dv3_reg   <= dv2_reg;
            den3_reg  <= xr2_reg - xl2_reg;
            ctl4_reg  <= ctl_c;
            dmag4_reg <= den3_reg[XW-1] ? (~den3_reg + 1'b1) : den3_reg;
            absb4_reg <= absb_c;
            d5_reg    <= d_c;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = d5_reg;

endmodule

`default_nettype wire

/* rtl/sdd_div.sv */
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none

module sdd_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  sdd_pkg::div_t in_item,
    output logic          out_valid,
    output sdd_pkg::div_t out_item
);
    import sdd_pkg::*;

    div_t link [Q_W+1];
    logic link_v [Q_W+1];

    assign link[0]   = in_item;
    assign link_v[0] = in_valid;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        div_t             st_reg;
        logic             v_reg;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] dext;
        logic             ge;
        div_t             nxt;

        assign rem_sh = {link[i].rem[REM_W-2:0], link[i].num[Q_W-1]};
        assign dext   = {1'b0, link[i].dmag};
        assign ge     = (rem_sh >= dext);

        always_comb
        begin
            nxt      = link[i];
            nxt.rem  = ge ? (rem_sh - dext) : rem_sh;
            nxt.num  = {link[i].num[Q_W-2:0], 1'b0};
            nxt.q    = {link[i].q[Q_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= link_v[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg <= nxt;
            end
        end

        assign link[i+1]   = st_reg;
        assign link_v[i+1] = v_reg;
    end

    assign out_valid = link_v[Q_W];
    assign out_item  = link[Q_W];

endmodule

`default_nettype wire

/* rtl/sdd_out.sv */
// Sign, saturation and output register with skid buffer
`default_nettype none

module sdd_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  sdd_pkg::div_t               in_item,
    output logic                        adv,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sdd_pkg::DEPTH_W-1:0] m_axis_tdata,
    output logic [1:0]                  m_axis_tuser
);
    import sdd_pkg::*;

    res_t res_c;
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic out_load;
    ctl_t c;

    assign c = in_item.ctl;

    always_comb
    begin
        res_c.depth       = '0;
        res_c.depth_valid = c.dvalid;
        res_c.saturated   = 1'b0;
        if (!c.dvalid)
        begin
            res_c.depth_valid = 1'b0;
        end
        else if (c.zero)
        begin
            res_c.saturated = 1'b1;
            res_c.depth     = c.base_neg ? DEPTH_MIN : (c.base_zero ? '0 : DEPTH_MAX);
        end
        else if (c.neg)
        begin
            // magnitude up to 2^31 still fits a negative result
            if (c.ovf || (in_item.q > DEPTH_MIN))
            begin
                res_c.saturated = 1'b1;
                res_c.depth     = DEPTH_MIN;
            end
            else
            begin
                res_c.depth = ~in_item.q + 1'b1;
            end
        end
        else
        begin
            if (c.ovf || in_item.q[Q_W-1])
            begin
                res_c.saturated = 1'b1;
                res_c.depth     = DEPTH_MAX;
            end
            else
            begin
                res_c.depth = in_item.q;
            end
        end
    end

    assign adv      = !skid_valid_reg;
    assign out_load = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (adv && in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_c;
        end
        else if (adv && in_valid)
        begin
            skid_reg <= res_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.depth;
    assign m_axis_tuser  = {out_reg.saturated, out_reg.depth_valid};

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid filled without an output stall");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.depth_valid)
            |-> (out_reg.depth == '0 && !out_reg.saturated))
        else $error("invalid pixel with nonzero depth or saturation");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.saturated)
            |-> (out_reg.depth == DEPTH_MIN || out_reg.depth == DEPTH_MAX
                 || out_reg.depth == '0))
        else $error("saturated depth is not a clamp value");
`endif

endmodule

`default_nettype wire

/* rtl/stereo_depth_from_disparity_top.sv */
// Pipeline: an input transaction reaches m_axis through 5 front stages,
//   32 divider stages of one quotient bit each and 1 output register.
// Throughput: one pixel per cycle; the pipeline stalls only while the output skid
//   buffer is full, which also drops s_axis_tready.
// Reset: rst_n clears all valid bits, those of the output and skid registers too,
//   and the configuration registers (all zero); datapath registers are not reset.
`default_nettype none

module stereo_depth_from_disparity_top (
    input  logic                       clk,
    input  logic                       rst_n,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sdd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // pixel input
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,   // [11:0] column, [27:12] disparity_value
    // depth output
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,   // [31:0] depth_value
    output logic [1:0]                 m_axis_tuser    // [0] depth_valid, [1] saturated
);
    import sdd_pkg::*;

    cfg_t cfg;
    logic adv;
    logic front_v;
    div_t front_d;
    logic div_v;
    div_t div_d;

    sdd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .cfg             (cfg),
        .in_valid        (s_axis_tvalid && adv),
        .column          (s_axis_tdata[COL_W-1:0]),
        .disparity_value (s_axis_tdata[COL_W+DISP_W-1:COL_W]),
        .out_valid       (front_v),
        .out_item        (front_d)
    );

    sdd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_v),
        .in_item   (front_d),
        .out_valid (div_v),
        .out_item  (div_d)
    );

    sdd_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (div_v),
        .in_item       (div_d),
        .adv           (adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign s_axis_tready = adv;

endmodule

`default_nettype wire
